// ===== sv/hpid_pkg.sv =====
// Shared types, register codes and reset values for the heater PID controller.
`timescale 1ns / 1ps
`default_nettype none

package hpid_pkg;

  localparam int unsigned TempW    = 11;
  localparam int unsigned GainW    = 16;
  localparam int unsigned LimitW   = 15;
  localparam int unsigned SumW     = 16;
  localparam int unsigned DriveW   = 8;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  // Register index codes
  typedef enum logic [CfgIdxW-1:0] {
    REG_CONTROL_MODE       = 3'd0,
    REG_TARGET_TEMPERATURE = 3'd1,
    REG_PROP_GAIN          = 3'd2,
    REG_INTEG_GAIN         = 3'd3,
    REG_DERIV_GAIN         = 3'd4,
    REG_INTEGRAL_LIMIT     = 3'd5
  } reg_idx_e;

  // Control mode codes
  typedef enum logic {
    MODE_BANG_BANG = 1'b0,
    MODE_PID       = 1'b1
  } mode_e;

  typedef struct packed {
    mode_e              control_mode;
    logic [TempW-1:0]   target_temperature;
    logic [GainW-1:0]   prop_gain;
    logic [GainW-1:0]   integ_gain;
    logic [GainW-1:0]   deriv_gain;
    logic [LimitW-1:0]  integral_limit;
  } cfg_t;

  localparam mode_e              RstControlMode   = MODE_PID;
  localparam logic [TempW-1:0]   RstTarget        = 11'd0;
  localparam logic [GainW-1:0]   RstPropGain      = 16'd256;
  localparam logic [GainW-1:0]   RstIntegGain     = 16'd64;
  localparam logic [GainW-1:0]   RstDerivGain     = 16'd256;
  localparam logic [LimitW-1:0]  RstIntegralLimit = 15'd1024;

  localparam logic [DriveW-1:0]  DriveMax = 8'd255;
  localparam logic [DriveW-1:0]  DriveOff = 8'd0;

endpackage

`default_nettype wire

// ===== sv/hpid_cfg_regs.sv =====
// Configuration register file for the heater PID controller.
`timescale 1ns / 1ps
`default_nettype none

module hpid_cfg_regs (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [hpid_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [hpid_pkg::CfgDataW-1:0] cfg_data_i,
  output hpid_pkg::cfg_t                     cfg_o
);

  hpid_pkg::cfg_t cfg_q, cfg_d;

  // Always take writes
  assign cfg_ready_o = 1'b1;

  // Decode the register index; drop writes beyond the list
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        hpid_pkg::REG_CONTROL_MODE:
          cfg_d.control_mode = hpid_pkg::mode_e'(cfg_data_i[0]);
        hpid_pkg::REG_TARGET_TEMPERATURE:
          cfg_d.target_temperature = cfg_data_i[hpid_pkg::TempW-1:0];
        hpid_pkg::REG_PROP_GAIN:
          cfg_d.prop_gain = cfg_data_i[hpid_pkg::GainW-1:0];
        hpid_pkg::REG_INTEG_GAIN:
          cfg_d.integ_gain = cfg_data_i[hpid_pkg::GainW-1:0];
        hpid_pkg::REG_DERIV_GAIN:
          cfg_d.deriv_gain = cfg_data_i[hpid_pkg::GainW-1:0];
        hpid_pkg::REG_INTEGRAL_LIMIT:
          cfg_d.integral_limit = cfg_data_i[hpid_pkg::LimitW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.control_mode       <= hpid_pkg::RstControlMode;
      cfg_q.target_temperature <= hpid_pkg::RstTarget;
      cfg_q.prop_gain          <= hpid_pkg::RstPropGain;
      cfg_q.integ_gain         <= hpid_pkg::RstIntegGain;
      cfg_q.deriv_gain         <= hpid_pkg::RstDerivGain;
      cfg_q.integral_limit     <= hpid_pkg::RstIntegralLimit;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ===== sv/hpid_calc.sv =====
// PID arithmetic, bang-bang bypass and controller state: error sum and previous sample.
`timescale 1ns / 1ps
`default_nettype none

module hpid_calc (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         update_i,
  input  wire logic [hpid_pkg::TempW-1:0]   meas_i,
  input  wire hpid_pkg::cfg_t               cfg_i,
  output logic [hpid_pkg::DriveW-1:0]       drive_o
);

  localparam int unsigned AccW = 35;

  logic signed [hpid_pkg::SumW-1:0] error_sum_q, error_sum_d;
  logic        [hpid_pkg::TempW-1:0] last_meas_q;

  logic signed [hpid_pkg::TempW:0]   err;
  logic signed [hpid_pkg::TempW:0]   delta;
  logic signed [hpid_pkg::SumW:0]    sum_raw;
  logic signed [hpid_pkg::SumW:0]    lim_pos;
  logic signed [hpid_pkg::SumW:0]    lim_neg;
  logic signed [hpid_pkg::GainW:0]   pg_s, ig_s, dg_s;
  logic signed [28:0]                p_term;
  logic signed [32:0]                i_term;
  logic signed [28:0]                d_term;
  logic signed [AccW-1:0]            acc;
  logic [hpid_pkg::DriveW-1:0]       pid_drive;
  logic                              pid_mode;

  assign pid_mode = (cfg_i.control_mode == hpid_pkg::MODE_PID);

  // Error and measurement change
  assign err   = $signed({1'b0, cfg_i.target_temperature}) - $signed({1'b0, meas_i});
  assign delta = $signed({1'b0, meas_i}) - $signed({1'b0, last_meas_q});

  // Accumulate and clamp the error sum
  assign sum_raw = (hpid_pkg::SumW+1)'(error_sum_q) + (hpid_pkg::SumW+1)'(err);
  assign lim_pos = $signed({2'b00, cfg_i.integral_limit});
  assign lim_neg = -lim_pos;

  always_comb begin
    if (sum_raw > lim_pos) begin
      error_sum_d = hpid_pkg::SumW'(lim_pos);
    end else if (sum_raw < lim_neg) begin
      error_sum_d = hpid_pkg::SumW'(lim_neg);
    end else begin
      error_sum_d = hpid_pkg::SumW'(sum_raw);
    end
  end

  // Weight the three terms; gains are unsigned Q8.8
  assign pg_s   = $signed({1'b0, cfg_i.prop_gain});
  assign ig_s   = $signed({1'b0, cfg_i.integ_gain});
  assign dg_s   = $signed({1'b0, cfg_i.deriv_gain});
  assign p_term = pg_s * err;
  assign i_term = ig_s * error_sum_d;
  assign d_term = dg_s * delta;
  assign acc    = AccW'(p_term) + AccW'(i_term) - AccW'(d_term);

  // Scale by 1/256 and clamp to the drive range
  always_comb begin
    if (acc < 35'sd256) begin
      pid_drive = hpid_pkg::DriveOff;
    end else if (|acc[AccW-2:16]) begin
      pid_drive = hpid_pkg::DriveMax;
    end else begin
      pid_drive = acc[15:8];
    end
  end

  // Bang-bang bypass
  always_comb begin
    if (pid_mode) begin
      drive_o = pid_drive;
    end else if (cfg_i.target_temperature > meas_i) begin
      drive_o = hpid_pkg::DriveMax;
    end else begin
      drive_o = hpid_pkg::DriveOff;
    end
  end

  // Advance state only for items handled in PID mode
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      error_sum_q <= '0;
      last_meas_q <= '0;
    end else if (update_i && pid_mode) begin
      error_sum_q <= error_sum_d;
      last_meas_q <= meas_i;
    end
  end

endmodule

`default_nettype wire

// ===== sv/heater_pid_controller_core.sv =====
// Top level of the heater PID controller: stream ports, pipeline registers, config port.
`timescale 1ns / 1ps
`default_nettype none

// Heater PID controller. Each temperature sample on the slave stream yields
// one heater drive value (0..255) on the master stream, by way of an input
// register and a result register. One sample is taken per cycle while the
// block does not stall; the rate is set by the error-sum update that each
// sample makes from the previous one. The block stalls only while both
// registers are full and the downstream side does not take the result.
// Configuration registers are written on the cfg port and take effect for any
// sample not yet in the result register; write them while no sample is in flight.
module heater_pid_controller_core (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // Sample stream
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  input  wire logic [15:0]                   s_axis_tdata,  // [10:0] measured_temp
  // Drive stream
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  output logic [7:0]                         m_axis_tdata,  // [7:0] heater_drive
  // Configuration writes
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [hpid_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [hpid_pkg::CfgDataW-1:0] cfg_data_i
);

  hpid_pkg::cfg_t cfg;

  logic                          in_valid_q, in_valid_d;
  logic [hpid_pkg::TempW-1:0]    meas_q;
  logic                          out_valid_q, out_valid_d;
  logic [hpid_pkg::DriveW-1:0]   drive_q, drive_d;
  logic                          advance;
  logic                          s_fire;

  hpid_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // Move the pipeline when the result register is free or being taken
  assign advance       = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !in_valid_q || advance;
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  hpid_calc u_calc (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .update_i (advance && in_valid_q),
    .meas_i   (meas_q),
    .cfg_i    (cfg),
    .drive_o  (drive_d)
  );

  // Valid flags for the two stages
  always_comb begin
    in_valid_d  = in_valid_q;
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = in_valid_q;
      in_valid_d  = 1'b0;
    end
    if (s_fire) begin
      in_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Capture sample and result payloads
  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      meas_q <= s_axis_tdata[hpid_pkg::TempW-1:0];
    end
    if (advance && in_valid_q) begin
      drive_q <= drive_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = drive_q;

endmodule

`default_nettype wire

// ===== tb/tb_heater_pid_controller_core.sv =====
// Self-checking testbench for the heater PID controller: predicts every drive and compares it.
`timescale 1ns / 1ps

module tb_heater_pid_controller_core;

  // Indexes past the register list; writes there must leave every register alone
  localparam logic [hpid_pkg::CfgIdxW-1:0] IdxSpareLow  = 3'd6;
  localparam logic [hpid_pkg::CfgIdxW-1:0] IdxSpareHigh = 3'd7;
  localparam int unsigned TempMax   = (1 << hpid_pkg::TempW) - 1;
  localparam int unsigned GainMax   = (1 << hpid_pkg::GainW) - 1;
  localparam int unsigned LimitMax  = (1 << hpid_pkg::LimitW) - 1;
  localparam int unsigned RandItems = 1850;

  // Tracks gains, target, error sum and previous sample; holds drives still owed
  class heater_drive_ledger;
    hpid_pkg::mode_e mode;
    int         target;
    int         kp;
    int         ki;
    int         kd;
    int         limit;
    int         err_sum;
    int         prev_meas;
    logic [hpid_pkg::DriveW-1:0] drive_due[$];
    int         faults;
    int         pid_samples;
    int         onoff_samples;
    int         drives_seen;

    function new();
      mode      = hpid_pkg::RstControlMode;
      target    = int'(hpid_pkg::RstTarget);
      kp        = int'(hpid_pkg::RstPropGain);
      ki        = int'(hpid_pkg::RstIntegGain);
      kd        = int'(hpid_pkg::RstDerivGain);
      limit     = int'(hpid_pkg::RstIntegralLimit);
      err_sum   = 0;
      prev_meas = 0;
    endfunction

    // Apply a register write, masked to the register width
    function void set_reg(logic [hpid_pkg::CfgIdxW-1:0] idx,
                          logic [hpid_pkg::CfgDataW-1:0] data);
      case (idx)
        hpid_pkg::REG_CONTROL_MODE:
          mode = hpid_pkg::mode_e'(data[0]);
        hpid_pkg::REG_TARGET_TEMPERATURE:
          target = int'(data[hpid_pkg::TempW-1:0]);
        hpid_pkg::REG_PROP_GAIN:
          kp = int'(data[hpid_pkg::GainW-1:0]);
        hpid_pkg::REG_INTEG_GAIN:
          ki = int'(data[hpid_pkg::GainW-1:0]);
        hpid_pkg::REG_DERIV_GAIN:
          kd = int'(data[hpid_pkg::GainW-1:0]);
        hpid_pkg::REG_INTEGRAL_LIMIT:
          limit = int'(data[hpid_pkg::LimitW-1:0]);
        default: ;
      endcase
    endfunction

    // Compute the drive for one sample and advance the loop state
    function logic [hpid_pkg::DriveW-1:0] predict_drive(int meas);
      int     err;
      int     sum;
      int     delta;
      longint acc;
      longint duty;
      if (mode == hpid_pkg::MODE_BANG_BANG) begin
        onoff_samples++;
        return (target > meas) ? hpid_pkg::DriveMax : hpid_pkg::DriveOff;
      end
      pid_samples++;
      err = target - meas;
      sum = err_sum + err;
      if (sum > limit) sum = limit;
      if (sum < -limit) sum = -limit;
      err_sum = sum;
      delta = meas - prev_meas;
      prev_meas = meas;
      acc = longint'(kp) * longint'(err) + longint'(ki) * longint'(sum)
          - longint'(kd) * longint'(delta);
      if (acc < 256) return hpid_pkg::DriveOff;
      duty = acc >>> 8;
      if (duty > 255) return hpid_pkg::DriveMax;
      return duty[hpid_pkg::DriveW-1:0];
    endfunction

    function void take_sample(logic [hpid_pkg::TempW-1:0] meas);
      drive_due.push_back(predict_drive(int'(meas)));
    endfunction

    function void match_drive(logic [hpid_pkg::DriveW-1:0] got);
      logic [hpid_pkg::DriveW-1:0] want;
      drives_seen++;
      if (drive_due.size() == 0) begin
        faults++;
        if (faults <= 10)
          $display("%0t: drive %0d arrived with no sample pending", $time, got);
        return;
      end
      want = drive_due.pop_front();
      if (got !== want) begin
        faults++;
        if (faults <= 10)
          $display("%0t: heater_drive expected %0d, got %0d", $time, want, got);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic                          s_axis_tvalid;
  logic                          s_axis_tready;
  logic [15:0]                   s_axis_tdata;   // [10:0] measured_temp
  logic                          m_axis_tvalid;
  logic                          m_axis_tready;
  logic [7:0]                    m_axis_tdata;   // [7:0] heater_drive
  logic                          cfg_valid;
  logic                          cfg_ready;
  logic [hpid_pkg::CfgIdxW-1:0]  cfg_index;
  logic [hpid_pkg::CfgDataW-1:0] cfg_data;

  logic src_steady;
  logic snk_steady;
  int   settings_used;

  heater_drive_ledger ledger = new();

  always #4 clk = ~clk;

  heater_pid_controller_core i_dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data)
  );

  // Watch all three handshakes at the rising edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (m_axis_tvalid && m_axis_tready) ledger.match_drive(m_axis_tdata);
      if (s_axis_tvalid && s_axis_tready)
        ledger.take_sample(s_axis_tdata[hpid_pkg::TempW-1:0]);
      if (cfg_valid && cfg_ready) ledger.set_reg(cfg_index, cfg_data);
    end
  end

  // Drive sink ready: a random stall, possibly none, before each item unless in a steady stretch
  initial begin : sink_ready
    int stall;
    m_axis_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      stall = snk_steady ? 0 : $urandom_range(0, 8);
      @(negedge clk);
      if (stall > 0) begin
        m_axis_tready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_axis_tready = 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
    end
  end

  // Offer one sample after a random gap; valid stays high for a back-to-back next item
  task automatic send_sample(input int meas);
    int gap;
    gap = src_steady ? 0 : $urandom_range(0, 8);
    @(negedge clk);
    if (gap > 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = {{(16 - hpid_pkg::TempW){1'b0}}, meas[hpid_pkg::TempW-1:0]};
    do @(posedge clk); while (!s_axis_tready);
  endtask

  task automatic write_reg(input logic [hpid_pkg::CfgIdxW-1:0] idx,
                           input logic [hpid_pkg::CfgDataW-1:0] data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Drop valid, wait for every owed drive, then let the pipeline empty
  task automatic settle();
    @(negedge clk);
    s_axis_tvalid = 1'b0;
    while (ledger.drive_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    settings_used++;
  endtask

  function automatic int pick_gain();
    case ($urandom_range(0, 5))
      0:       return 0;
      1:       return GainMax;
      2:       return $urandom_range(0, GainMax);
      default: return $urandom_range(0, 768);
    endcase
  endfunction

  // One random setting followed by a run of samples, mostly a drifting walk
  task automatic run_phase(input int count);
    int tgt;
    int lim;
    int walk;
    hpid_pkg::mode_e mode;
    src_steady = ($urandom_range(0, 3) == 0);
    snk_steady = ($urandom_range(0, 3) == 0);
    mode = ($urandom_range(0, 4) == 0) ? hpid_pkg::MODE_BANG_BANG : hpid_pkg::MODE_PID;
    case ($urandom_range(0, 3))
      0:       tgt = 0;
      1:       tgt = TempMax;
      default: tgt = $urandom_range(0, TempMax);
    endcase
    case ($urandom_range(0, 4))
      0:       lim = 0;
      1:       lim = LimitMax;
      2:       lim = $urandom_range(0, LimitMax);
      default: lim = $urandom_range(1, 300);
    endcase
    write_reg(hpid_pkg::REG_CONTROL_MODE, {15'($urandom), mode});
    write_reg(hpid_pkg::REG_TARGET_TEMPERATURE, {5'($urandom), tgt[hpid_pkg::TempW-1:0]});
    write_reg(hpid_pkg::REG_PROP_GAIN, 16'(pick_gain()));
    write_reg(hpid_pkg::REG_INTEG_GAIN, 16'(pick_gain()));
    write_reg(hpid_pkg::REG_DERIV_GAIN, 16'(pick_gain()));
    write_reg(hpid_pkg::REG_INTEGRAL_LIMIT, {1'($urandom), lim[hpid_pkg::LimitW-1:0]});
    if ($urandom_range(0, 3) == 0)
      write_reg($urandom_range(0, 1) ? IdxSpareHigh : IdxSpareLow, 16'($urandom));
    walk = tgt + $urandom_range(0, 100) - 50;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(0, 15))
        0:       walk = $urandom_range(0, TempMax);
        1:       walk = $urandom_range(0, 1) ? TempMax : 0;
        default: walk = walk + $urandom_range(0, 40) - 20;
      endcase
      if (walk < 0) walk = 0;
      if (walk > TempMax) walk = TempMax;
      send_sample(walk);
    end
    settle();
  endtask

  initial begin : run
    int sent;
    int chunk;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    cfg_valid     = 1'b0;
    cfg_index     = hpid_pkg::REG_CONTROL_MODE;
    cfg_data      = '0;
    src_steady    = 1'b0;
    snk_steady    = 1'b0;
    settings_used = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Reset setting: target zero, a big downward step makes the derivative term win
    send_sample(0);
    send_sample(TempMax);
    send_sample(1);
    send_sample(0);
    settle();

    // Zero integral limit with full proportional and integral gains, no derivative gain
    write_reg(hpid_pkg::REG_TARGET_TEMPERATURE, 16'(TempMax));
    write_reg(hpid_pkg::REG_INTEGRAL_LIMIT, 16'd0);
    write_reg(hpid_pkg::REG_PROP_GAIN, 16'(GainMax));
    write_reg(hpid_pkg::REG_INTEG_GAIN, 16'(GainMax));
    write_reg(hpid_pkg::REG_DERIV_GAIN, 16'd0);
    send_sample(0);
    send_sample(TempMax);
    send_sample(TempMax - 1);
    settle();

    // On/off mode around the target, with extra bits set in the written values
    write_reg(hpid_pkg::REG_CONTROL_MODE, {15'h7FFF, hpid_pkg::MODE_BANG_BANG});
    write_reg(hpid_pkg::REG_TARGET_TEMPERATURE, {5'h1F, 11'd1000});
    send_sample(999);
    send_sample(1000);
    send_sample(1001);
    send_sample(0);
    send_sample(TempMax);
    settle();

    // Ignored indexes, then integral clamp on both sides
    write_reg(IdxSpareLow, 16'hFFFF);
    write_reg(IdxSpareHigh, 16'hFFFF);
    write_reg(hpid_pkg::REG_CONTROL_MODE, {15'd0, hpid_pkg::MODE_PID});
    write_reg(hpid_pkg::REG_TARGET_TEMPERATURE, 16'd100);
    write_reg(hpid_pkg::REG_INTEGRAL_LIMIT, 16'd5);
    write_reg(hpid_pkg::REG_PROP_GAIN, 16'd0);
    send_sample(0);
    send_sample(0);
    send_sample(200);
    send_sample(200);
    settle();

    // Widest limit via a masked write, derivative at full gain, a negative weighted total
    write_reg(hpid_pkg::REG_INTEGRAL_LIMIT, 16'hFFFF);
    write_reg(hpid_pkg::REG_INTEG_GAIN, 16'd256);
    write_reg(hpid_pkg::REG_DERIV_GAIN, 16'(GainMax));
    write_reg(hpid_pkg::REG_TARGET_TEMPERATURE, 16'd1024);
    send_sample(0);
    send_sample(0);
    send_sample(TempMax);
    send_sample(1024);
    send_sample(1023);
    send_sample(512);
    settle();

    sent = 0;
    while (sent < RandItems) begin
      chunk = $urandom_range(60, 200);
      if (chunk > RandItems - sent) chunk = RandItems - sent;
      run_phase(chunk);
      sent += chunk;
    end

    $display("Checked %0d drives: %0d PID and %0d on/off samples over %0d register settings.",
             ledger.drives_seen, ledger.pid_samples, ledger.onoff_samples, settings_used);
    $display("Gains, target and limit included their extremes; both sides stalled at random.");
    if (ledger.faults == 0 && ledger.drive_due.size() == 0) begin
      $display("heater_pid_controller_core: match");
    end else begin
      $display("heater_pid_controller_core: mismatch");
    end
    $finish;
  end

  // Stop a hung run
  initial begin : watchdog
    #4000000;
    $display("Timed out with %0d drives still owed", ledger.drive_due.size());
    $display("heater_pid_controller_core: mismatch");
    $finish;
  end

endmodule

// ===== heater_pid_controller_core.f =====
sv/hpid_pkg.sv
sv/hpid_cfg_regs.sv
sv/hpid_calc.sv
sv/heater_pid_controller_core.sv
tb/tb_heater_pid_controller_core.sv
